FILE: hw/rtl/bmtm_pkg.sv
// Shared types, codes and helpers for the button menu threshold monitor.
// No dependencies; imported by every module of the block.
package bmtm_pkg;

    // Field widths fixed by the item and result formats
    localparam int unsigned FUNC_W  = 3;
    localparam int unsigned TIME_W  = 32;
    localparam int unsigned TEMP_W  = 16;
    localparam int unsigned SOUND_W = 8;
    localparam int unsigned THR_W   = 10;
    localparam int unsigned DEB_W   = 16;
    localparam int unsigned STEP_W  = 7;
    localparam int unsigned CIDX_W  = 2;
    localparam int unsigned CDATA_W = 16;

    // Menu states, in display order
    typedef enum logic [3:0] {
        ST_HOME,
        ST_EXTREME,
        ST_MAX_SHOW,
        ST_MAX_SET,
        ST_MAX_INC,
        ST_MAX_DEC,
        ST_MIN_SHOW,
        ST_MIN_SET,
        ST_MIN_INC,
        ST_MIN_DEC,
        ST_MUS_SHOW,
        ST_MUS_SET,
        ST_MUS_CONF
    } menu_state_t;

    // Request function codes
    localparam logic [FUNC_W-1:0] FN_UP     = 3'd0;
    localparam logic [FUNC_W-1:0] FN_DOWN   = 3'd1;
    localparam logic [FUNC_W-1:0] FN_SET    = 3'd2;
    localparam logic [FUNC_W-1:0] FN_CANCEL = 3'd3;
    localparam logic [FUNC_W-1:0] FN_SAMPLE = 3'd4;

    // Sound flag codes
    localparam logic [SOUND_W-1:0] SND_QUIET  = 8'd0;
    localparam logic [SOUND_W-1:0] SND_ACTIVE = 8'd1;

    // Configuration register indexes
    localparam logic [CIDX_W-1:0] CFG_DEBOUNCE = 2'd0;
    localparam logic [CIDX_W-1:0] CFG_CEILING  = 2'd1;
    localparam logic [CIDX_W-1:0] CFG_FLOOR    = 2'd2;
    localparam logic [CIDX_W-1:0] CFG_STEP     = 2'd3;

    typedef struct packed {
        logic [DEB_W-1:0]  debounce_window;
        logic [THR_W-1:0]  upper_ceiling;
        logic [THR_W-1:0]  lower_floor;
        logic [STEP_W-1:0] edit_step;
    } cfg_t;

    localparam cfg_t CFG_RESET = '{
        debounce_window: 16'd300,
        upper_ceiling:   10'd360,
        lower_floor:     10'd150,
        edit_step:       7'd10
    };

    typedef struct packed {
        logic [FUNC_W-1:0]  func;
        logic [TIME_W-1:0]  event_time;
        logic [TEMP_W-1:0]  temp_raw;
        logic [SOUND_W-1:0] sound_flag;
    } item_t;

    typedef struct packed {
        menu_state_t       menu;
        logic [THR_W-1:0]  upper_limit;
        logic [THR_W-1:0]  lower_limit;
        logic [THR_W-1:0]  edit_upper;
        logic [THR_W-1:0]  edit_lower;
        logic              music_flag;
        logic [TIME_W-1:0] last_press;
        logic [TEMP_W-1:0] highest_seen;
        logic [TEMP_W-1:0] lowest_seen;
        logic              band_alarm;
        logic              sound_alarm;
    } state_t;

    localparam state_t STATE_RESET = '{
        menu:         ST_HOME,
        upper_limit:  10'd240,
        lower_limit:  10'd220,
        edit_upper:   10'd0,
        edit_lower:   10'd0,
        music_flag:   1'b0,
        last_press:   32'd0,
        highest_seen: 16'd0,
        lowest_seen:  16'd0,
        band_alarm:   1'b0,
        sound_alarm:  1'b0
    };

    // Add a step, saturate at the threshold field's top value
    function automatic logic [THR_W-1:0] add_sat(input logic [THR_W-1:0]  a,
                                                 input logic [STEP_W-1:0] b);
        logic [THR_W:0] s;
        s = {1'b0, a} + {{(THR_W-STEP_W+1){1'b0}}, b};
        return s[THR_W] ? {THR_W{1'b1}} : s[THR_W-1:0];
    endfunction

    // Subtract a step, stop at zero
    function automatic logic [THR_W-1:0] sub_floor(input logic [THR_W-1:0]  a,
                                                   input logic [STEP_W-1:0] b);
        logic [THR_W-1:0] bw;
        bw = {{(THR_W-STEP_W){1'b0}}, b};
        return (bw > a) ? '0 : a - bw;
    endfunction

endpackage

FILE: hw/rtl/bmtm_step.sv
// Next-state logic for one request: debounce, menu move, entry action, sample update.
// Depends on bmtm_pkg.
module bmtm_step (
    input  bmtm_pkg::cfg_t   cfg,
    input  bmtm_pkg::item_t  item,
    input  bmtm_pkg::state_t cur,
    output bmtm_pkg::state_t nxt,
    output logic             accepted
);
    import bmtm_pkg::*;

    logic [TIME_W-1:0] elapsed;
    logic              press_ok;

    assign elapsed  = item.event_time - cur.last_press;
    assign press_ok = elapsed > {{(TIME_W-DEB_W){1'b0}}, cfg.debounce_window};

    always_comb begin
        nxt      = cur;
        accepted = 1'b0;
        if (item.func <= FN_CANCEL) begin
            if (press_ok) begin
                accepted       = 1'b1;
                nxt.last_press = item.event_time;
                // menu move, with the set-press side effects
                unique case (item.func)
                    FN_UP: begin
                        unique case (cur.menu)
                            ST_HOME:                 nxt.menu = ST_EXTREME;
                            ST_EXTREME:              nxt.menu = ST_MAX_SHOW;
                            ST_MAX_SHOW:             nxt.menu = ST_MIN_SHOW;
                            ST_MIN_SHOW:             nxt.menu = ST_MUS_SHOW;
                            ST_MAX_SET, ST_MAX_DEC:  nxt.menu = ST_MAX_INC;
                            ST_MIN_SET, ST_MIN_DEC:  nxt.menu = ST_MIN_INC;
                            default:                 nxt.menu = cur.menu;
                        endcase
                    end
                    FN_DOWN: begin
                        unique case (cur.menu)
                            ST_MUS_SHOW:             nxt.menu = ST_MIN_SHOW;
                            ST_MIN_SHOW:             nxt.menu = ST_MAX_SHOW;
                            ST_MAX_SHOW:             nxt.menu = ST_EXTREME;
                            ST_EXTREME:              nxt.menu = ST_HOME;
                            ST_MAX_SET, ST_MAX_INC:  nxt.menu = ST_MAX_DEC;
                            ST_MIN_SET, ST_MIN_INC:  nxt.menu = ST_MIN_DEC;
                            default:                 nxt.menu = cur.menu;
                        endcase
                    end
                    FN_SET: begin
                        unique case (cur.menu)
                            ST_MAX_SHOW: begin
                                nxt.edit_upper = cur.upper_limit;
                                nxt.menu       = ST_MAX_SET;
                            end
                            ST_MAX_SET, ST_MAX_INC, ST_MAX_DEC: begin
                                nxt.upper_limit = cur.edit_upper;
                                nxt.menu        = ST_MAX_SHOW;
                            end
                            ST_MIN_SHOW: begin
                                nxt.edit_lower = cur.lower_limit;
                                nxt.menu       = ST_MIN_SET;
                            end
                            ST_MIN_SET, ST_MIN_INC, ST_MIN_DEC: begin
                                nxt.lower_limit = cur.edit_lower;
                                nxt.menu        = ST_MIN_SHOW;
                            end
                            ST_MUS_SHOW: nxt.menu = ST_MUS_SET;
                            ST_MUS_SET: begin
                                nxt.music_flag = ~cur.music_flag;
                                nxt.menu       = ST_MUS_CONF;
                            end
                            default: nxt.menu = cur.menu;
                        endcase
                    end
                    default: begin
                        unique case (cur.menu)
                            ST_MAX_SET, ST_MAX_INC, ST_MAX_DEC: nxt.menu = ST_MAX_SHOW;
                            ST_MIN_SET, ST_MIN_INC, ST_MIN_DEC: nxt.menu = ST_MIN_SHOW;
                            ST_MUS_SET:                         nxt.menu = ST_MUS_SHOW;
                            default:                            nxt.menu = cur.menu;
                        endcase
                    end
                endcase
                // entry action of the state just reached
                unique case (nxt.menu)
                    ST_MAX_INC: begin
                        if (nxt.edit_upper < cfg.upper_ceiling)
                            nxt.edit_upper = add_sat(nxt.edit_upper, cfg.edit_step);
                    end
                    ST_MAX_DEC: begin
                        if (nxt.edit_upper > nxt.lower_limit)
                            nxt.edit_upper = sub_floor(nxt.edit_upper, cfg.edit_step);
                    end
                    ST_MIN_INC: begin
                        if (nxt.edit_lower < nxt.upper_limit)
                            nxt.edit_lower = add_sat(nxt.edit_lower, cfg.edit_step);
                    end
                    ST_MIN_DEC: begin
                        if (nxt.edit_lower > cfg.lower_floor)
                            nxt.edit_lower = sub_floor(nxt.edit_lower, cfg.edit_step);
                    end
                    ST_MUS_CONF: nxt.menu = ST_MUS_SHOW;
                    default: ;
                endcase
            end
        end else if (item.func == FN_SAMPLE) begin
            if (cur.menu == ST_HOME) begin
                accepted = 1'b1;
                if (item.temp_raw > cur.highest_seen)
                    nxt.highest_seen = item.temp_raw;
                if (item.temp_raw < cur.lowest_seen || cur.lowest_seen == '0)
                    nxt.lowest_seen = item.temp_raw;
                nxt.band_alarm =
                    (item.temp_raw < {{(TEMP_W-THR_W){1'b0}}, cur.lower_limit}) ||
                    (item.temp_raw > {{(TEMP_W-THR_W){1'b0}}, cur.upper_limit});
                if (item.sound_flag == SND_ACTIVE)
                    nxt.sound_alarm = 1'b1;
                else if (item.sound_flag == SND_QUIET)
                    nxt.sound_alarm = 1'b0;
            end
        end
    end

endmodule

FILE: hw/rtl/button_menu_threshold_monitor.sv
// Button menu threshold monitor: a request passes the input register and then the result register,
// one request per cycle while the result channel is not stalled; the step logic is a single pass.
// A request sits in the input register and the step logic loads state and the result register
// when it advances; a waiting result holds the request there, and s_ready drops when both are
// full and the result is not taken. Reset (aresetn low, synchronous) returns menu, thresholds,
// records and registers to defaults and empties both stages.
module button_menu_threshold_monitor (
    input  logic                           aclk,
    input  logic                           aresetn,
    // configuration write port
    input  logic                           cfg_wr_en,
    input  logic [bmtm_pkg::CIDX_W-1:0]    cfg_index,
    input  logic [bmtm_pkg::CDATA_W-1:0]   cfg_wr_data,
    // request channel
    input  logic                           s_valid,
    output logic                           s_ready,
    input  logic [bmtm_pkg::FUNC_W-1:0]    s_func,
    input  logic [bmtm_pkg::TIME_W-1:0]    s_event_time,
    input  logic [bmtm_pkg::TEMP_W-1:0]    s_temp_raw,
    input  logic [bmtm_pkg::SOUND_W-1:0]   s_sound_flag,
    // result channel
    output logic                           m_valid,
    input  logic                           m_ready,
    output logic                           m_accepted,
    output logic [3:0]                     m_menu_state,
    output logic [bmtm_pkg::THR_W-1:0]     m_max_threshold,
    output logic [bmtm_pkg::THR_W-1:0]     m_min_threshold,
    output logic [bmtm_pkg::THR_W-1:0]     m_pending_max,
    output logic [bmtm_pkg::THR_W-1:0]     m_pending_min,
    output logic                           m_music_on,
    output logic [bmtm_pkg::TEMP_W-1:0]    m_record_high,
    output logic [bmtm_pkg::TEMP_W-1:0]    m_record_low,
    output logic                           m_temp_alarm,
    output logic                           m_baby_alarm
);
    import bmtm_pkg::*;

    cfg_t   cfg_reg;
    state_t state_reg;
    state_t state_next;
    logic   accepted_next;

    // input stage
    logic   in_valid_reg;
    item_t  in_item_reg;

    // result stage
    logic   out_valid_reg;
    logic   out_accepted_reg;
    state_t out_state_reg;

    logic   advance;

    // Move the held request into the result stage when that stage is empty or draining.
    assign advance = in_valid_reg && (!out_valid_reg || m_ready);
    // Take a new request whenever the input stage is empty or empties in this cycle.
    assign s_ready = !in_valid_reg || advance;

    // Configuration writes: hold values masked to each register's width.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg <= CFG_RESET;
        end else if (cfg_wr_en) begin
            unique case (cfg_index)
                CFG_DEBOUNCE: cfg_reg.debounce_window <= cfg_wr_data[DEB_W-1:0];
                CFG_CEILING:  cfg_reg.upper_ceiling   <= cfg_wr_data[THR_W-1:0];
                CFG_FLOOR:    cfg_reg.lower_floor     <= cfg_wr_data[THR_W-1:0];
                CFG_STEP:     cfg_reg.edit_step       <= cfg_wr_data[STEP_W-1:0];
            endcase
        end
    end

    // Input register: valid bit is control, payload needs no reset.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg <= 1'b0;
        end else if (s_ready) begin
            in_valid_reg <= s_valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_valid && s_ready) begin
            in_item_reg <= '{func:       s_func,
                             event_time: s_event_time,
                             temp_raw:   s_temp_raw,
                             sound_flag: s_sound_flag};
        end
    end

    // Single pass: debounce, menu move, entry action, or sample update.
    bmtm_step u_step (
        .cfg      (cfg_reg),
        .item     (in_item_reg),
        .cur      (state_reg),
        .nxt      (state_next),
        .accepted (accepted_next)
    );

    // Commit state only when the request moves on, so the next one sees it at once.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= STATE_RESET;
        end else if (advance) begin
            state_reg <= state_next;
        end
    end

    // Result register: drop valid once taken, refill on advance.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg <= 1'b0;
        end else if (advance) begin
            out_valid_reg <= 1'b1;
        end else if (m_ready) begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (advance) begin
            out_accepted_reg <= accepted_next;
            out_state_reg    <= state_next;
        end
    end

    assign m_valid         = out_valid_reg;
    assign m_accepted      = out_accepted_reg;
    assign m_menu_state    = out_state_reg.menu;
    assign m_max_threshold = out_state_reg.upper_limit;
    assign m_min_threshold = out_state_reg.lower_limit;
    assign m_pending_max   = out_state_reg.edit_upper;
    assign m_pending_min   = out_state_reg.edit_lower;
    assign m_music_on      = out_state_reg.music_flag;
    assign m_record_high   = out_state_reg.highest_seen;
    assign m_record_low    = out_state_reg.lowest_seen;
    assign m_temp_alarm    = out_state_reg.band_alarm;
    assign m_baby_alarm    = out_state_reg.sound_alarm;

endmodule

FILE: hw/rtl/bmtm_checker.sv
// Port-level checks for the button menu threshold monitor, bound to the top level.
// Depends on bmtm_pkg and button_menu_threshold_monitor.
module bmtm_checker (
    input logic                         aclk,
    input logic                         aresetn,
    input logic                         m_valid,
    input logic                         m_ready,
    input logic                         m_accepted,
    input logic [3:0]                   m_menu_state,
    input logic [bmtm_pkg::TEMP_W-1:0]  m_record_high,
    input logic [bmtm_pkg::TEMP_W-1:0]  m_record_low
);
    import bmtm_pkg::*;

    // A stalled result holds.
    a_result_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_ready |=> m_valid && $stable(m_menu_state) && $stable(m_accepted)
                                && $stable(m_record_high) && $stable(m_record_low))
        else $error("result changed while stalled");

    // The music confirm state passes straight through to music show.
    a_no_confirm: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid |-> m_menu_state != ST_MUS_CONF)
        else $error("music confirm state reported");

    // Once a low record exists, it never exceeds the high record.
    a_record_order: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_record_low != '0 |-> m_record_low <= m_record_high)
        else $error("record low above record high");

    // Reset empties the result stage.
    a_reset_empty: assert property (@(posedge aclk)
        !aresetn |=> !m_valid)
        else $error("result valid after reset");

endmodule

bind button_menu_threshold_monitor bmtm_checker u_bmtm_checker (
    .aclk          (aclk),
    .aresetn       (aresetn),
    .m_valid       (m_valid),
    .m_ready       (m_ready),
    .m_accepted    (m_accepted),
    .m_menu_state  (m_menu_state),
    .m_record_high (m_record_high),
    .m_record_low  (m_record_low)
);
